>>> rtl/tbdlp_pkg.sv
// Package for the two-button debounce with long press.
// Holds the event codes, register indexes and reset values.
// No dependencies.
package tbdlp_pkg;

  // Event codes given once per poll.
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_SHORT_ONE = 2'd1,
    EV_SHORT_TWO = 2'd2,
    EV_LONG      = 2'd3
  } event_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_DEBOUNCE   = 1'b0,
    REG_LONG_PRESS = 1'b1
  } reg_idx_e;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [DebounceW-1:0] DebounceReset  = 16'd50;
  localparam logic [TimeW-1:0]     LongPressReset = 32'd5000;

endpackage

>>> rtl/tbdlp_ifs.sv
// Valid/ready channel interfaces for the poll requests and the event results.
// Depends on tbdlp_pkg for the field widths.
interface tbdlp_poll_if;
  import tbdlp_pkg::*;
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_ms;
  logic             level_one;
  logic             level_two;

  modport source (output valid, output now_ms, output level_one, output level_two,
                  input ready);
  modport sink (input valid, input now_ms, input level_one, input level_two,
                output ready);
endinterface

interface tbdlp_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

>>> rtl/two_button_debounce_long_press.sv
// Two-button debounce with a both-held long press; one event per poll request.
// The poll is captured in the input register, and its event moves to the result
// register once that register is empty or being taken by the receiver.
// Throughput: one poll per cycle while the receiver takes events; an input register
// and a result register bracket one 32-bit subtract and compare per time check.
// Reset (rst_ni low, asynchronous): buttons released, no hold, stamps zero,
// debounce 50 ms, long press 5000 ms. Depends on tbdlp_pkg and tbdlp_ifs.
module two_button_debounce_long_press
  import tbdlp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  tbdlp_poll_if.sink     in_ch,
  tbdlp_event_if.source  out_ch
);

  // Configuration registers.
  logic [DebounceW-1:0] debounce_q;
  logic [TimeW-1:0]     long_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      long_press_q <= LongPressReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_DEBOUNCE:   debounce_q   <= cfg_wdata_i[DebounceW-1:0];
        REG_LONG_PRESS: long_press_q <= cfg_wdata_i[TimeW-1:0];
        default:        ;
      endcase
    end
  end

  // Input register stage.
  logic             s1_valid_q;
  logic [TimeW-1:0] now_q;
  logic             lvl1_q, lvl2_q;
  logic             out_valid_q;
  logic [1:0]       event_q;
  logic             s1_advance;

  assign s1_advance   = !out_valid_q || out_ch.ready;
  assign in_ch.ready  = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      now_q  <= in_ch.now_ms;
      lvl1_q <= in_ch.level_one;
      lvl2_q <= in_ch.level_two;
    end
  end

  // Button and hold state.
  logic             prev1_q, prev1_d, prev2_q, prev2_d;
  logic [TimeW-1:0] stamp1_q, stamp1_d, stamp2_q, stamp2_d;
  logic [TimeW-1:0] hold_start_q, hold_start_d;
  logic             hold_active_q, hold_active_d;
  logic             hold_fired_q, hold_fired_d;
  event_e           event_d;

  logic [TimeW-1:0] hold_start_eff, hold_diff, diff1, diff2;
  logic             deb1_ok, deb2_ok, edge1;

  // Step logic for the poll held in the input register.
  always_comb begin
    prev1_d       = prev1_q;
    prev2_d       = prev2_q;
    stamp1_d      = stamp1_q;
    stamp2_d      = stamp2_q;
    hold_start_d  = hold_start_q;
    hold_active_d = hold_active_q;
    hold_fired_d  = hold_fired_q;
    event_d       = EV_NONE;
    edge1         = 1'b0;

    hold_start_eff = hold_active_q ? hold_start_q : now_q;
    hold_diff      = now_q - hold_start_eff;
    diff1          = now_q - stamp1_q;
    diff2          = now_q - stamp2_q;
    deb1_ok        = diff1 > {{(TimeW-DebounceW){1'b0}}, debounce_q};
    deb2_ok        = diff2 > {{(TimeW-DebounceW){1'b0}}, debounce_q};

    if (!lvl1_q && !lvl2_q) begin
      // Both held: start or continue the hold, fire the long press once.
      hold_active_d = 1'b1;
      hold_start_d  = hold_start_eff;
      if (!hold_fired_q && (hold_diff >= long_press_q)) begin
        hold_fired_d = 1'b1;
        event_d      = EV_LONG;
      end else begin
        prev1_d = 1'b0;
        prev2_d = 1'b0;
      end
    end else if (hold_active_q && lvl1_q && lvl2_q) begin
      // Both released after a hold: end it with no event.
      hold_active_d = 1'b0;
      hold_fired_d  = 1'b0;
      prev1_d       = 1'b1;
      prev2_d       = 1'b1;
    end else begin
      // Independent debounce; button 1 has priority.
      if ((lvl1_q != prev1_q) && deb1_ok) begin
        stamp1_d = now_q;
        prev1_d  = lvl1_q;
        edge1    = !lvl1_q;
      end
      if (edge1) begin
        event_d = EV_SHORT_ONE;
      end else if ((lvl2_q != prev2_q) && deb2_ok) begin
        stamp2_d = now_q;
        prev2_d  = lvl2_q;
        if (!lvl2_q) begin
          event_d = EV_SHORT_TWO;
        end
      end
    end
  end

  // State and result registers, updated as the poll moves to the output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev1_q       <= 1'b1;
      prev2_q       <= 1'b1;
      stamp1_q      <= '0;
      stamp2_q      <= '0;
      hold_start_q  <= '0;
      hold_active_q <= 1'b0;
      hold_fired_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      event_q       <= EV_NONE;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        prev1_q       <= prev1_d;
        prev2_q       <= prev2_d;
        stamp1_q      <= stamp1_d;
        stamp2_q      <= stamp2_d;
        hold_start_q  <= hold_start_d;
        hold_active_q <= hold_active_d;
        hold_fired_q  <= hold_fired_d;
        event_q       <= event_d;
      end
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.event_code = event_q;

endmodule

>>> bench/tb_two_button_debounce_long_press.sv
// Self-checking bench for the two-button debounce with long press: a directed
// table of polls, then randomized poll phases under several register settings.
// Depends on tbdlp_pkg, tbdlp_ifs and the two_button_debounce_long_press RTL.
`timescale 1ns / 1ps

module tb_two_button_debounce_long_press;
  import tbdlp_pkg::*;

  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned RX_STALL_CYCLES = 300;
  // About 1300 requests plus drains and one long receiver hold-off, taken several times over.
  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned SCRIPT_ROWS     = 28;

  // One row of the directed table: either a poll request or a register update.
  typedef struct {
    bit          reconfig;
    logic [31:0] stamp;
    logic        b1;
    logic        b2;
    bit          typed;
    event_e      want;
    logic [15:0] db;
    logic [31:0] lp;
  } script_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  tbdlp_poll_if  poll_ch ();
  tbdlp_event_if ev_ch ();

  two_button_debounce_long_press dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (poll_ch),
    .out_ch      (ev_ch)
  );

  // Shadow of the block's registers and button state.
  logic [15:0] cfg_db;
  logic [31:0] cfg_lp;
  logic        lvl_one;
  logic        lvl_two;
  logic [31:0] stamp_one;
  logic [31:0] stamp_two;
  logic [31:0] hold_t0;
  logic        hold_on;
  logic        hold_done;

  event_e      owed_events [$];
  int unsigned fault_count;
  int unsigned cycle_count;
  bit          no_gaps;
  bit          rx_stall_req;
  logic [31:0] clock_ms;
  script_row_t poll_script [SCRIPT_ROWS];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Works out the event of one poll and advances the shadow state.
  function automatic event_e judge_poll(input logic [31:0] t, input logic b1,
                                        input logic b2);
    logic [31:0] span;
    event_e      ev;
    ev = EV_NONE;
    if (!b1 && !b2) begin
      if (!hold_on) begin
        hold_t0 = t;
        hold_on = 1'b1;
      end
      span = t - hold_t0;
      if (!hold_done && span >= cfg_lp) begin
        hold_done = 1'b1;
        return EV_LONG;
      end
      lvl_one = 1'b0;
      lvl_two = 1'b0;
      return EV_NONE;
    end
    // Releasing both buttons ends the hold and gives nothing.
    if (hold_on && b1 && b2) begin
      hold_on   = 1'b0;
      hold_done = 1'b0;
      lvl_one   = 1'b1;
      lvl_two   = 1'b1;
      return EV_NONE;
    end
    span = t - stamp_one;
    if (b1 != lvl_one && span > {16'd0, cfg_db}) begin
      stamp_one = t;
      if (!b1) ev = EV_SHORT_ONE;
      lvl_one = b1;
    end
    // Button two is only looked at when button one gave no press.
    span = t - stamp_two;
    if (ev == EV_NONE && b2 != lvl_two && span > {16'd0, cfg_db}) begin
      stamp_two = t;
      if (!b2) ev = EV_SHORT_TWO;
      lvl_two = b2;
    end
    return ev;
  endfunction

  // Offers one poll request after a random gap and records its event once accepted.
  task automatic send_poll(input logic [31:0] t, input logic b1, input logic b2,
                           input bit typed, input event_e want);
    int unsigned gap;
    event_e      ev;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    poll_ch.valid     <= 1'b1;
    poll_ch.now_ms    <= t;
    poll_ch.level_one <= b1;
    poll_ch.level_two <= b2;
    @(posedge clk_i);
    while (!poll_ch.ready) @(posedge clk_i);
    ev = judge_poll(t, b1, b2);
    owed_events.push_back(typed ? want : ev);
    @(negedge clk_i);
  endtask

  // Stops offering requests and waits until every owed event has come back.
  task automatic drain_polls();
    poll_ch.valid <= 1'b0;
    while (owed_events.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Writes both registers while the block is idle; junk in the unused data bits.
  task automatic apply_config(input logic [15:0] db, input logic [31:0] lp);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_DEBOUNCE;
    cfg_wdata <= {junk, db};
    @(negedge clk_i);
    cfg_idx   <= REG_LONG_PRESS;
    cfg_wdata <= lp;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    cfg_db = db;
    cfg_lp = lp;
  endtask

  // Random polls: time steps scaled to the current registers, button levels
  // that mostly persist so that presses and holds build up.
  task automatic run_random_phase(input int unsigned count);
    int unsigned pick;
    logic [31:0] step;
    logic        b1;
    logic        b2;
    b1 = 1'b1;
    b2 = 1'b1;
    for (int unsigned k = 0; k < count; k++) begin
      if (k == count / 2) drain_polls();
      pick = $urandom_range(0, 99);
      if (pick < 30) step = $urandom_range(0, cfg_db);
      else if (pick < 60) step = $urandom_range(cfg_db, 2 * cfg_db + 2);
      else if (pick < 78) step = $urandom_range(0, cfg_lp / 4 + 1);
      else if (pick < 86) step = cfg_lp - $urandom_range(0, 1);
      else if (pick < 95) step = $urandom;
      else step = '1;
      clock_ms += step;
      pick = $urandom_range(0, 99);
      if (pick < 20) b1 = ~b1;
      else if (pick < 35) b2 = ~b2;
      else if (pick < 47) {b1, b2} = 2'b00;
      else if (pick < 57) {b1, b2} = 2'b11;
      else if (pick < 60) {b1, b2} = 2'($urandom);
      send_poll(clock_ms, b1, b2, 1'b0, EV_NONE);
    end
  endtask

  // Event receiver: random back-pressure, plus one long hold-off on request.
  initial begin : event_sink
    int unsigned gap;
    ev_ch.ready = 1'b0;
    @(negedge clk_i);
    while (!rst_ni) @(negedge clk_i);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (rx_stall_req) begin
        gap = RX_STALL_CYCLES;
        rx_stall_req = 1'b0;
      end
      if (gap != 0) begin
        ev_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      ev_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!ev_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Compare each accepted event with the oldest one owed.
  always @(posedge clk_i) begin : event_check
    event_e want;
    if (rst_ni && ev_ch.valid && ev_ch.ready) begin
      if (owed_events.size() == 0) begin
        fault_count++;
        $error("event_code: no event owed, actual %0d", ev_ch.event_code);
      end else begin
        want = owed_events.pop_front();
        if (ev_ch.event_code !== want) begin
          fault_count++;
          $error("event_code mismatch: expected %0d, actual %0d", want,
                 ev_ch.event_code);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    poll_ch.valid     = 1'b0;
    poll_ch.now_ms    = '0;
    poll_ch.level_one = 1'b1;
    poll_ch.level_two = 1'b1;
    cfg_we            = 1'b0;
    cfg_idx           = REG_DEBOUNCE;
    cfg_wdata         = '0;
    fault_count       = 0;
    cycle_count       = 0;
    no_gaps           = 1'b0;
    rx_stall_req      = 1'b0;
    clock_ms          = '0;
    cfg_db            = DebounceReset;
    cfg_lp            = LongPressReset;
    lvl_one           = 1'b1;
    lvl_two           = 1'b1;
    stamp_one         = '0;
    stamp_two         = '0;
    hold_t0           = '0;
    hold_on           = 1'b0;
    hold_done         = 1'b0;

    // Directed table; typed expectations only where obvious.
    poll_script = '{
      '{0, 32'd100,        1, 1, 1, EV_NONE,      16'd0, 32'd0}, // quiet after reset
      '{0, 32'd200,        0, 1, 1, EV_SHORT_ONE, 16'd0, 32'd0},
      '{0, 32'd220,        1, 1, 0, EV_NONE,      16'd0, 32'd0}, // bounce rejected
      '{0, 32'd260,        1, 1, 0, EV_NONE,      16'd0, 32'd0},
      '{0, 32'd300,        1, 0, 1, EV_SHORT_TWO, 16'd0, 32'd0},
      '{0, 32'd310,        0, 1, 0, EV_NONE,      16'd0, 32'd0}, // exactly at debounce
      '{0, 32'd311,        0, 1, 0, EV_NONE,      16'd0, 32'd0}, // button 1 press; button 2 still in debounce
      '{0, 32'd400,        1, 1, 0, EV_NONE,      16'd0, 32'd0}, // release while 2 moves
      '{0, 32'd1000,       0, 0, 0, EV_NONE,      16'd0, 32'd0}, // hold begins
      '{0, 32'd3000,       0, 1, 0, EV_NONE,      16'd0, 32'd0}, // one let go mid-hold
      '{0, 32'd5999,       0, 0, 0, EV_NONE,      16'd0, 32'd0},
      '{0, 32'd6000,       0, 0, 1, EV_LONG,      16'd0, 32'd0},
      '{0, 32'd6500,       0, 0, 0, EV_NONE,      16'd0, 32'd0}, // fires only once
      '{0, 32'd7000,       1, 1, 0, EV_NONE,      16'd0, 32'd0}, // hold ends
      '{0, 32'd7001,       0, 1, 0, EV_NONE,      16'd0, 32'd0},
      '{0, 32'd7100,       1, 1, 0, EV_NONE,      16'd0, 32'd0},
      '{0, 32'hFFFF_FFF0,  1, 0, 0, EV_NONE,      16'd0, 32'd0},
      '{0, 32'h0000_0030,  1, 1, 0, EV_NONE,      16'd0, 32'd0}, // across the wrap
      '{0, 32'h0000_0010,  1, 0, 0, EV_NONE,      16'd0, 32'd0}, // time goes back
      '{0, 32'hFFFF_FFFF,  0, 0, 0, EV_NONE,      16'd0, 32'd0},
      '{0, 32'h0000_1387,  0, 0, 1, EV_LONG,      16'd0, 32'd0}, // hold spans the wrap
      '{0, 32'd5000,       1, 1, 0, EV_NONE,      16'd0, 32'd0},
      '{1, 32'd0,          1, 1, 0, EV_NONE,      16'd0, 32'd0}, // zero times
      '{0, 32'd10,         0, 0, 1, EV_LONG,      16'd0, 32'd0},
      '{0, 32'd10,         1, 1, 0, EV_NONE,      16'd0, 32'd0},
      '{0, 32'd10,         0, 1, 0, EV_NONE,      16'd0, 32'd0},
      '{0, 32'd10,         1, 1, 0, EV_NONE,      16'd0, 32'd0},
      '{0, 32'd11,         1, 0, 0, EV_NONE,      16'd0, 32'd0}
    };

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (poll_script[r]) begin
      if (poll_script[r].reconfig) begin
        drain_polls();
        apply_config(poll_script[r].db, poll_script[r].lp);
      end else begin
        send_poll(poll_script[r].stamp, poll_script[r].b1, poll_script[r].b2,
                  poll_script[r].typed, poll_script[r].want);
      end
    end

    // Back to the reset values.
    drain_polls();
    apply_config(DebounceReset, LongPressReset);
    clock_ms = 32'd20000;
    run_random_phase(220);

    // Zero times, with neither side idling.
    drain_polls();
    no_gaps = 1'b1;
    apply_config(16'd0, 32'd0);
    run_random_phase(200);

    // Largest times, starting just before the wrap.
    drain_polls();
    no_gaps = 1'b0;
    apply_config(16'hFFFF, 32'hFFFF_FFFF);
    clock_ms = 32'hFFFF_0000;
    run_random_phase(200);

    // Moderate times; the receiver holds off long enough to fill the block.
    drain_polls();
    apply_config(16'($urandom_range(1, 300)), $urandom_range(200, 4000));
    rx_stall_req = 1'b1;
    run_random_phase(220);

    drain_polls();
    apply_config(16'd1, 32'd1);
    run_random_phase(200);

    drain_polls();
    apply_config(16'($urandom), $urandom);
    run_random_phase(200);

    drain_polls();
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
